FILE: rtl/cls_pkg.sv
// Shared types, widths and constants for the channel level smoother.
package cls_pkg;

    localparam int CHAN_W     = 3;
    localparam int SAMPLE_W   = 12;
    localparam int SPEED_W    = 2;
    localparam int COEF_W     = 16;
    localparam int TARGET_W   = 24;
    localparam int LEVEL_W    = 25;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 17;
    localparam int ACC_W      = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0] DEAD_BAND      = 12'd20;
    localparam logic [TARGET_W-1:0] ZERO_THRESHOLD = 24'd117440;
    localparam logic [LEVEL_W-1:0]  LEVEL_ONE      = 25'h1000000;
    localparam logic [MUL_B_W-1:0]  COEF_ONE       = 17'h10000;
    localparam logic [ACC_W-1:0]    ROUND_HALF     = 42'd32768;

    localparam logic [CHAN_W-1:0]  CHAN_FIRST      = 3'd0;
    localparam logic [CHAN_W-1:0]  CHAN_LAST_FIXED = 3'd5;
    localparam logic [SPEED_W-1:0] SPEED_FAST      = 2'd0;
    localparam logic [SPEED_W-1:0] SPEED_SLOW      = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY  = 2'd1;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] level_cv;
        logic [SAMPLE_W-1:0] slider;
        logic                edit_scales_mode;
        logic [SPEED_W-1:0]  env_speed;
    } cls_sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_channel;
        logic [LEVEL_W-1:0] level;
    } cls_result_t;

    // Controller to datapath commands, one step per cycle unless a stalled result holds write back.
    typedef struct packed {
        logic load;
        logic tgt;
        logic mul_old;
        logic mul_tgt;
        logic wb;
    } cls_cmd_t;

    typedef struct packed {
        logic out_full;
    } cls_status_t;

endpackage

FILE: rtl/cls_ctrl.sv
// Sequencing state machine for the channel level smoother.
module cls_ctrl
    import cls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic        result_stall,
    input  cls_status_t status,
    output cls_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TGT  = 5'b00010,
        ST_MA   = 5'b00100,
        ST_MB   = 5'b01000,
        ST_WB   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   wb_go;
    logic   accept_ok;
    logic   load;

    // Write back only when the output register is free or being drained.
    assign wb_go     = (state_reg == ST_WB) && !(status.out_full && result_stall);
    assign accept_ok = (state_reg == ST_IDLE) || wb_go;
    assign load      = sample_valid && accept_ok;

    assign sample_stall = !accept_ok;

    always_comb
    begin
        cmd         = '0;
        cmd.load    = load;
        cmd.tgt     = (state_reg == ST_TGT);
        cmd.mul_old = (state_reg == ST_MA);
        cmd.mul_tgt = (state_reg == ST_MB);
        cmd.wb      = wb_go;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = load ? ST_TGT : ST_IDLE;
            ST_TGT:  state_next = ST_MA;
            ST_MA:   state_next = ST_MB;
            ST_MB:   state_next = ST_WB;
            ST_WB:
            begin
                if (wb_go)
                begin
                    state_next = load ? ST_TGT : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> (state_reg == ST_TGT))
        else $error("accepted beat did not start the target step");

    a_wb_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |-> !(status.out_full && result_stall))
        else $error("write back over a stalled result");

    a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_old |=> cmd.mul_tgt)
        else $error("second product did not follow the first");

endmodule

FILE: rtl/cls_datapath.sv
// Datapath: coefficient registers, level store, shared multiplier, output register.
module cls_datapath
    import cls_pkg::*;
#(
    parameter int NUM_CHANS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cls_cmd_t              cmd,
    output cls_status_t           status,
    input  cls_sample_t           sample,
    input  logic                  result_stall,
    output logic                  result_valid,
    output cls_result_t           result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_CHANS > 1) ? $clog2(NUM_CHANS) : 1;

    logic [COEF_W-1:0]   attack_reg;
    logic [COEF_W-1:0]   decay_reg;
    logic [LEVEL_W-1:0]  levels_reg [NUM_CHANS];

    logic [CHAN_W-1:0]   ch_reg;
    logic [SAMPLE_W-1:0] cv_reg;
    logic [SAMPLE_W-1:0] s_reg;
    logic                edit_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [LEVEL_W-1:0]  old_reg;
    logic [COEF_W-1:0]   coef_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                out_valid_reg;
    cls_result_t         out_reg;

    logic [SAMPLE_W-1:0] s_next;
    logic [TARGET_W-1:0] target_next;
    logic [COEF_W-1:0]   coef_next;
    logic [ACC_W-1:0]    acc_next;
    logic                out_valid_next;
    logic [LEVEL_W-1:0]  level_next;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [ACC_W-1:0]    prod;
    logic                in_range;
    logic [IDX_W-1:0]    idx;
    logic [LEVEL_W-1:0]  fixed_level;

    assign in_range = (int'(ch_reg) < NUM_CHANS);
    assign idx      = IDX_W'(ch_reg);

    // Dead band on the slider.
    assign s_next = (sample.slider < DEAD_BAND) ? '0 : (sample.slider - DEAD_BAND);

    // One multiplier shared by the target, old*c and target*(1-c) products.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.tgt)
        begin
            mul_a = MUL_A_W'(cv_reg);
            mul_b = MUL_B_W'(s_reg);
        end
        else if (cmd.mul_old)
        begin
            mul_a = old_reg;
            mul_b = MUL_B_W'(coef_next);
        end
        else if (cmd.mul_tgt)
        begin
            mul_a = MUL_A_W'(target_reg);
            mul_b = COEF_ONE - MUL_B_W'(coef_reg);
        end
    end

    assign prod = ACC_W'(mul_a) * ACC_W'(mul_b);

    assign target_next = (prod[TARGET_W-1:0] <= ZERO_THRESHOLD) ? '0 : prod[TARGET_W-1:0];
    assign coef_next   = (old_reg < LEVEL_W'(target_reg)) ? attack_reg : decay_reg;
    assign acc_next    = cmd.mul_tgt ? (acc_reg + prod + ROUND_HALF) : prod;

    always_comb
    begin
        fixed_level = '0;
        if (ch_reg == CHAN_FIRST)
        begin
            fixed_level = (speed_reg != SPEED_SLOW) ? LEVEL_ONE : '0;
        end
        else if (ch_reg == CHAN_LAST_FIXED)
        begin
            fixed_level = (speed_reg != SPEED_FAST) ? LEVEL_ONE : '0;
        end
    end

    always_comb
    begin
        level_next = '0;
        if (in_range)
        begin
            level_next = edit_reg ? fixed_level : acc_reg[LEVEL_W+15:16];
        end
    end

    assign out_valid_next = cmd.wb || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg    <= '0;
            decay_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANS; i++)
            begin
                levels_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == REG_ATTACK))
            begin
                attack_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_DECAY))
            begin
                decay_reg <= cfg_data;
            end
            if (cmd.wb && in_range)
            begin
                levels_reg[idx] <= level_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg    <= sample.channel;
            cv_reg    <= sample.level_cv;
            s_reg     <= s_next;
            edit_reg  <= sample.edit_scales_mode;
            speed_reg <= sample.env_speed;
        end
        if (cmd.tgt)
        begin
            target_reg <= target_next;
            old_reg    <= in_range ? levels_reg[idx] : '0;
        end
        if (cmd.mul_old)
        begin
            coef_reg <= coef_next;
        end
        if (cmd.mul_old || cmd.mul_tgt)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.wb)
        begin
            out_reg.out_channel <= ch_reg;
            out_reg.level       <= level_next;
        end
    end

    assign status.out_full = out_valid_reg;
    assign result_valid    = out_valid_reg;
    assign result          = out_reg;

    a_wb_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |=> result_valid)
        else $error("write back did not present a result");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.level <= LEVEL_ONE))
        else $error("level above full scale");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wb && !in_range) |=> (result.level == '0))
        else $error("unknown channel produced a nonzero level");

endmodule

FILE: rtl/channel_level_smoother_core.sv
// Top level of the channel level smoother: controller plus datapath.
// A result beat is written to the output register in the write-back step, after the
// target product, old*c and target*(1-c) steps; the single shared multiplier serves these
// in turn, so a new sample is taken only once the previous one reaches write-back.
// The next sample is taken in the write-back cycle unless a stalled result holds the output.
// Reset (rst_n low, asynchronous) zeroes all channel levels and both coefficients.
module channel_level_smoother_core
    import cls_pkg::*;
#(
    parameter int NUM_CHANS = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample channel: one channel's CV, slider and mode bits per beat
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  cls_sample_t           sample,
    // result channel: the channel's new smoothed level per beat
    output logic                  result_valid,
    input  logic                  result_stall,
    output cls_result_t           result,
    // configuration writes: index 0 attack coefficient, index 1 decay coefficient
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cls_cmd_t    cmd;
    cls_status_t status;

    // Coefficient registers take a write on any cycle.
    assign cfg_ready = 1'b1;

    // Sequence each sample: load, target product, old*c, target*(1-c) with
    // rounding, then write back to the level store and the output register.
    cls_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    // Dead band, target threshold, one-pole filter and edit-mode forcing.
    cls_datapath #(
        .NUM_CHANS (NUM_CHANS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample       (sample),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule
